@@ rtl/rpn_stack_calculator_defines.svh @@
// ----------------------------------------------------------------------------
// rpn_stack_calculator_defines.svh
// Assertion shorthands shared by the calculator modules. Each macro expects
// clk and rst to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RPN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared widths, opcode and status codes, and the control/status bundles
// between the calculator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;
  localparam int DEPTH_W = 7;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_MOD     = 3'd5,
    OP_FINISH  = 3'd6,
    OP_UNKNOWN = 3'd7
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_DIV  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  // controller to datapath strobes
  typedef struct packed {
    logic accept;
    logic latch_ops;
    logic div_start;
    logic eval;
    logic commit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    opcode_t op;
    logic    div_zero;
    logic    div_done;
    logic    out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/rpn_cmd_if.sv @@
// ----------------------------------------------------------------------------
// rpn_cmd_if
// Command channel: opcode plus fixed-point operand, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpn_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [rpn_pkg::CMD_W-1:0]         command;
  logic signed [rpn_pkg::DATA_W-1:0] operand_value;

  modport source (output valid, output command, output operand_value, input ready);
  modport sink   (input valid, input command, input operand_value, output ready);
endinterface

`default_nettype wire

@@ rtl/rpn_res_if.sv @@
// ----------------------------------------------------------------------------
// rpn_res_if
// Result channel: top of stack, status code and depth, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpn_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [rpn_pkg::DATA_W-1:0] top_value;
  logic [rpn_pkg::STAT_W-1:0]        status;
  logic [rpn_pkg::DEPTH_W-1:0]       stack_depth;

  modport source (output valid, output top_value, output status, output stack_depth,
                  input ready);
  modport sink   (input valid, input top_value, input status, input stack_depth,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/rpn_ram.sv @@
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rpn_div.sv @@
// ----------------------------------------------------------------------------
// rpn_div
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per
// cycle. done pulses for one cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quot[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    fits    = ~diff[DEN_W+1];
  end

  // control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath: quotient shifts in from the bottom as the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], fits};
      rem  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rpn_dp.sv @@
// ----------------------------------------------------------------------------
// rpn_dp
// Calculator datapath: stack RAM with cached top entry, operand fetch,
// arithmetic with saturation, shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rpn_stack_calculator_defines.svh"

module rpn_dp #(
  parameter int STACK_DEPTH   = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rpn_pkg::CMD_W-1:0]         command,
  input  logic signed [rpn_pkg::DATA_W-1:0] operand_value,
  input  rpn_pkg::dp_cmd_t                  ctl,
  output rpn_pkg::dp_stat_t                 stat,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic signed [rpn_pkg::DATA_W-1:0] top_value,
  output logic [rpn_pkg::STAT_W-1:0]        status,
  output logic [rpn_pkg::DEPTH_W-1:0]       stack_depth
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int NW = 32 + FRACTION_BITS;
  localparam logic [31:0]   FRAC_MASK = 32'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic [31:0]   SAT_MAX   = 32'h7fff_ffff;
  localparam logic [31:0]   SAT_MIN   = 32'h8000_0000;
  localparam logic [NW-1:0] MAG_LIM   = NW'(64'h8000_0000);

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // stack state and per-item registers
  logic [CW-1:0]       count;
  logic signed [31:0]  top;
  rpn_pkg::opcode_t    cmd_q;
  logic signed [31:0]  opnd_q;
  logic signed [31:0]  a_q;
  logic signed [31:0]  b_q;
  logic signed [63:0]  prod_q;
  logic [31:0]         below_q;
  logic [31:0]         res_q;
  logic                neg_q;

  // result register
  logic                out_valid;
  logic [31:0]         out_top;
  rpn_pkg::status_t    out_status;
  logic [6:0]          out_depth;

  // ram port signals
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [31:0]         ram_rdata;

  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       cnt_m2;
  logic                cnt0;
  logic                cnt_lt2;
  logic                full;

  assign cnt_m1  = count - CW'(1);
  assign cnt_m2  = count - CW'(2);
  assign cnt0    = (count == '0);
  assign cnt_lt2 = (count < CW'(2));
  assign full    = (count == CW'(STACK_DEPTH));

  // entry below the top is fetched when a command is taken
  assign ram_raddr = cnt_m2[AW-1:0];

  rpn_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q  <= rpn_pkg::opcode_t'(command);
      opnd_q <= operand_value;
    end
  end

  // operand select: empty slots read as zero
  logic signed [31:0] a_sel;
  logic signed [31:0] b_sel;

  assign b_sel = cnt0 ? 32'sd0 : top;
  assign a_sel = cnt_lt2 ? 32'sd0 : $signed(ram_rdata);

  always_ff @(posedge clk) begin
    if (ctl.latch_ops) begin
      a_q     <= a_sel;
      b_q     <= b_sel;
      below_q <= ram_rdata;
      prod_q  <= a_sel * b_sel;
    end
  end

  // divider setup: integer parts for mod, scaled dividend for div
  logic signed [31:0] a_adj;
  logic signed [31:0] b_adj;
  logic signed [31:0] a_int;
  logic signed [31:0] b_int;
  logic               is_mod;
  logic [31:0]        den_src;
  logic [NW-1:0]      div_num;
  logic [31:0]        div_den;
  logic               div_zero;
  logic               div_neg;
  logic               div_done;
  logic [NW-1:0]      div_quot;
  logic [31:0]        div_rem;

  always_comb begin
    a_adj    = a_q + $signed(a_q[31] ? FRAC_MASK : 32'd0);
    b_adj    = b_q + $signed(b_q[31] ? FRAC_MASK : 32'd0);
    a_int    = a_adj >>> FRACTION_BITS;
    b_int    = b_adj >>> FRACTION_BITS;
    is_mod   = (cmd_q == rpn_pkg::OP_MOD);
    den_src  = is_mod ? b_int : b_q;
    div_den  = abs32(den_src);
    div_zero = (den_src == 32'd0);
    div_num  = is_mod ? NW'(abs32(a_int)) : (NW'(abs32(a_q)) << FRACTION_BITS);
    div_neg  = is_mod ? a_q[31] : (a_q[31] ^ b_q[31]);
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      neg_q <= div_neg;
    end
  end

  rpn_div #(
    .NUM_W (NW),
    .DEN_W (32)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // result evaluation with saturation
  logic [32:0]        sum33;
  logic [32:0]        dif33;
  logic signed [63:0] prod_sh;
  logic [31:0]        mul_res;
  logic [31:0]        quo_res;
  logic [31:0]        rem_sh;
  logic [31:0]        mod_res;
  logic [31:0]        eval_res;

  always_comb begin
    sum33   = {a_q[31], a_q} + {b_q[31], b_q};
    dif33   = {a_q[31], a_q} - {b_q[31], b_q};
    prod_sh = prod_q >>> FRACTION_BITS;
    if ((&prod_sh[63:31]) || !(|prod_sh[63:31])) begin
      mul_res = prod_sh[31:0];
    end else begin
      mul_res = prod_sh[63] ? SAT_MIN : SAT_MAX;
    end
    if (neg_q) begin
      quo_res = (div_quot > MAG_LIM) ? SAT_MIN : (32'd0 - div_quot[31:0]);
    end else begin
      quo_res = (div_quot > (MAG_LIM - NW'(1))) ? SAT_MAX : div_quot[31:0];
    end
    rem_sh  = div_rem << FRACTION_BITS;
    mod_res = neg_q ? (32'd0 - rem_sh) : rem_sh;
    unique case (cmd_q)
      rpn_pkg::OP_ADD: eval_res = sat33(sum33);
      rpn_pkg::OP_SUB: eval_res = sat33(dif33);
      rpn_pkg::OP_MUL: eval_res = mul_res;
      rpn_pkg::OP_DIV: eval_res = quo_res;
      rpn_pkg::OP_MOD: eval_res = mod_res;
      default:         eval_res = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      res_q <= eval_res;
    end
  end

  // commit: stack update, ram write and reported values
  logic             we;
  logic [CW-1:0]    cnt_nx;
  logic [31:0]      top_nx;
  rpn_pkg::status_t st;
  logic             report_pop;
  logic [31:0]      out_top_nx;
  logic [CW+6:0]    depth_ext;

  always_comb begin
    we         = 1'b0;
    ram_waddr  = cnt_m2[AW-1:0];
    ram_wdata  = res_q;
    cnt_nx     = count;
    top_nx     = top;
    st         = rpn_pkg::ST_OK;
    report_pop = 1'b0;
    unique case (cmd_q)
      rpn_pkg::OP_PUSH: begin
        if (full) begin
          st = rpn_pkg::ST_OVERFLOW;
        end else begin
          we        = 1'b1;
          ram_waddr = count[AW-1:0];
          ram_wdata = opnd_q;
          top_nx    = opnd_q;
          cnt_nx    = count + CW'(1);
        end
      end
      rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
      rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
        if ((cmd_q == rpn_pkg::OP_DIV || cmd_q == rpn_pkg::OP_MOD) && div_zero) begin
          // divisor popped, nothing pushed
          st     = cnt0 ? rpn_pkg::ST_UNDERFLOW : rpn_pkg::ST_ZERO_DIV;
          cnt_nx = cnt0 ? '0 : cnt_m1;
          top_nx = below_q;
        end else begin
          // pop two, push the result
          st        = cnt_lt2 ? rpn_pkg::ST_UNDERFLOW : rpn_pkg::ST_OK;
          cnt_nx    = cnt_lt2 ? CW'(1) : cnt_m1;
          we        = 1'b1;
          ram_waddr = cnt_lt2 ? '0 : cnt_m2[AW-1:0];
          top_nx    = res_q;
        end
      end
      rpn_pkg::OP_FINISH: begin
        st         = cnt0 ? rpn_pkg::ST_UNDERFLOW : rpn_pkg::ST_OK;
        cnt_nx     = cnt0 ? '0 : cnt_m1;
        top_nx     = below_q;
        report_pop = 1'b1;
      end
      default: begin
        st = rpn_pkg::ST_UNKNOWN;
      end
    endcase
    if (report_pop) begin
      out_top_nx = cnt0 ? 32'd0 : top;
    end else begin
      out_top_nx = (cnt_nx == '0) ? 32'd0 : top_nx;
    end
    depth_ext = {7'd0, cnt_nx};
    ram_we    = ctl.commit & we;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.commit) begin
      count <= cnt_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      top        <= top_nx;
      out_top    <= out_top_nx;
      out_status <= st;
      out_depth  <= depth_ext[6:0];
    end
  end

  // result register: free when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res_valid   = out_valid;
  assign top_value   = out_top;
  assign status      = out_status;
  assign stack_depth = out_depth;

  assign stat.op       = cmd_q;
  assign stat.div_zero = div_zero;
  assign stat.div_done = div_done;
  assign stat.out_free = ~out_valid | res_ready;

  // checks
  `RPN_ASSERT_SAME(a_depth_bound, 1'b1, count <= CW'(STACK_DEPTH), "stack count above depth")
  `RPN_ASSERT_NEXT(a_commit_shows, ctl.commit, out_valid, "commit did not load result")
  `RPN_ASSERT_NEXT(a_unknown_keeps, ctl.commit && cmd_q == rpn_pkg::OP_UNKNOWN,
                   $stable(count), "unknown command changed depth")

endmodule

`default_nettype wire

@@ rtl/rpn_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpn_ctrl
// Calculator sequencer: accept, operand fetch, divider run, evaluate, commit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rpn_stack_calculator_defines.svh"

module rpn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rpn_pkg::dp_stat_t stat,
  output rpn_pkg::dp_cmd_t  ctl
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_OPER   = 6'b000010,
    S_DIVS   = 6'b000100,
    S_DIVW   = 6'b001000,
    S_EVAL   = 6'b010000,
    S_COMMIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_OPER;
        end
      end
      S_OPER: begin
        if (stat.op == rpn_pkg::OP_DIV || stat.op == rpn_pkg::OP_MOD) begin
          state_next = S_DIVS;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_DIVS: begin
        state_next = stat.div_zero ? S_EVAL : S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // strobes to the datapath
  assign cmd_ready     = (state == S_IDLE);
  assign ctl.accept    = cmd_ready & cmd_valid;
  assign ctl.latch_ops = (state == S_OPER);
  assign ctl.div_start = (state == S_DIVS) & ~stat.div_zero;
  assign ctl.eval      = (state == S_EVAL);
  assign ctl.commit    = (state == S_COMMIT) & stat.out_free;

  // checks
  `RPN_ASSERT_NEXT(a_accept_fetch, ctl.accept, state == S_OPER, "accept not followed by fetch")
  `RPN_ASSERT_SAME(a_commit_free, ctl.commit, stat.out_free, "commit into busy result slot")
  `RPN_ASSERT_NEXT(a_div_to_eval, state == S_DIVW && stat.div_done, state == S_EVAL,
                   "divider finish missed")

endmodule

`default_nettype wire

@@ rtl/rpn_stack_calculator.sv @@
// Reverse-Polish calculator on a stack of signed fixed-point values
// (FRACTION_BITS fraction bits, STACK_DEPTH entries held in one RAM with the
// top entry cached in a register). Every command transfer yields exactly one
// result transfer carrying the top of stack, a status code and the depth.
// Push, add, sub, mul, finish and unknown commands each run these steps: accept
// with RAM read of the entry below the top, operand latch and multiply,
// evaluate, commit. Div and mod add a test of the divisor before evaluate and,
// when it is nonzero, wait for the radix-2 divider, which produces one quotient
// bit per cycle over a 32 + FRACTION_BITS bit dividend (48 bits at Q16.16).
// A new command is taken while the previous result still waits; the commit
// stalls only while the result register is full and not being taken. The
// stack RAM needs no initialization after reset.
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Top level: joins the sequencer and the datapath to the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator #(
  parameter int STACK_DEPTH   = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  rpn_cmd_if.sink   cmd,
  rpn_res_if.source res
);

  rpn_pkg::dp_cmd_t  ctl;
  rpn_pkg::dp_stat_t stat;

  // sequencer
  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // stack, arithmetic and result register
  rpn_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .command       (cmd.command),
    .operand_value (cmd.operand_value),
    .ctl           (ctl),
    .stat          (stat),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .top_value     (res.top_value),
    .status        (res.status),
    .stack_depth   (res.stack_depth)
  );

endmodule

`default_nettype wire
